// ----- rtl/afs_pkg.sv -----
`timescale 1ns / 1ps

package afs_pkg;

  // frame_status codes
  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [3:0]  SYNC_NIB   = 4'hF;
  localparam logic [12:0] MIN_LENGTH = 13'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int TDATA_BITS = 48;

  // One accepted byte yields zero, one or two results; a pair always shares its header fields.
  typedef struct packed {
    logic        two;         // pair: sync byte first, then byte1
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [1:0]  status;      // status of the final result of the entry
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [12:0] frame_length;
    logic [15:0] frame_number;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   full;
    logic   empty;
  } qstat_t;

endpackage

// ----- rtl/afs_front.sv -----
`timescale 1ns / 1ps

module afs_front #(
  parameter int FRAME_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output afs_pkg::push_t    push
);

  typedef enum logic [1:0] {PH_SEARCH, PH_GOT_FF, PH_FRAME} phase_t;

  phase_t                      phase, phase_next;
  logic [12:0]                 pos, pos_next;
  logic [1:0]                  profile, profile_next;
  logic [3:0]                  rate_index, rate_index_next;
  logic [12:0]                 length, length_next;
  logic [FRAME_COUNT_BITS-1:0] count, count_next;
  afs_pkg::push_t              push_next;
  logic [13:0]                 pos_inc;
  logic [31:0]                 count_ext;
  logic                        done;

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    profile_next    = profile;
    rate_index_next = rate_index;
    length_next     = length;
    count_next      = count;
    done            = 1'b0;
    pos_inc         = {1'b0, pos} + 14'd1;
    count_ext       = 32'(count);
    push_next       = '0;
    push_next.entry.byte0  = data_byte;
    push_next.entry.byte1  = data_byte;
    push_next.entry.status = afs_pkg::ST_INSIDE;
    if (accept) begin
      unique case (phase)
        PH_SEARCH: begin
          if (data_byte == afs_pkg::SYNC_BYTE && !stream_end) phase_next = PH_GOT_FF;
        end
        PH_GOT_FF: begin
          if (data_byte[7:4] != afs_pkg::SYNC_NIB) begin
            phase_next = PH_SEARCH;
          end else begin
            profile_next    = '0;
            rate_index_next = '0;
            length_next     = '0;
            push_next.valid        = 1'b1;
            push_next.entry.two    = 1'b1;
            push_next.entry.byte0  = afs_pkg::SYNC_BYTE;
            push_next.entry.status = stream_end ? afs_pkg::ST_TRUNC : afs_pkg::ST_INSIDE;
            pos_next   = 13'd2;
            phase_next = stream_end ? PH_SEARCH : PH_FRAME;
          end
        end
        PH_FRAME: begin
          case (pos)
            13'd2: begin
              profile_next    = data_byte[7:6];
              rate_index_next = data_byte[5:2];
            end
            13'd3: length_next = {data_byte[1:0], 11'd0};
            13'd4: length_next = length | {2'b00, data_byte, 3'b000};
            13'd5: begin
              length_next = length | {10'd0, data_byte[7:5]};
              if (length_next < afs_pkg::MIN_LENGTH) begin
                done = 1'b1;
                push_next.entry.status = afs_pkg::ST_BADLEN;
              end
            end
            default: begin
              if (pos >= 13'd6 && pos_inc >= {1'b0, length}) begin
                done = 1'b1;
                push_next.entry.status = afs_pkg::ST_DONE;
                count_next = count + FRAME_COUNT_BITS'(1);
              end
            end
          endcase
          if (!done && stream_end) push_next.entry.status = afs_pkg::ST_TRUNC;
          push_next.valid = 1'b1;
          if (done || stream_end) begin
            phase_next = PH_SEARCH;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc[12:0];
          end
        end
        default: phase_next = PH_SEARCH;
      endcase
    end
    push_next.entry.profile      = profile_next;
    push_next.entry.rate_index   = rate_index_next;
    push_next.entry.frame_length = length_next;
    // frame number is the count before this byte
    push_next.entry.frame_number = count_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      pos        <= '0;
      profile    <= '0;
      rate_index <= '0;
      length     <= '0;
      count      <= '0;
      push       <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      profile    <= profile_next;
      rate_index <= rate_index_next;
      length     <= length_next;
      count      <= count_next;
      push       <= push_next;
    end
  end

endmodule

// ----- rtl/afs_queue.sv -----
`timescale 1ns / 1ps

module afs_queue (
  input  logic             clk,
  input  logic             rst,
  input  afs_pkg::push_t   push,
  input  logic             pop,
  output afs_pkg::entry_t  head,
  output afs_pkg::qstat_t  stat
);

  afs_pkg::entry_t              mem [afs_pkg::QDEPTH];
  logic [afs_pkg::QAW-1:0]      wr_ptr, rd_ptr;
  logic [afs_pkg::QAW:0]        level;
  logic                         do_pop;

  // one slot kept spare: the front has a request in flight after ready drops
  assign stat.full  = level >= 3'(afs_pkg::QDEPTH - 1);
  assign stat.empty = level == '0;
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + {{(afs_pkg::QAW-1){1'b0}}, 1'b1};
      if (do_pop) rd_ptr <= rd_ptr + {{(afs_pkg::QAW-1){1'b0}}, 1'b1};
      level <= level + {2'b00, push.valid} - {2'b00, do_pop};
    end
  end

endmodule

// ----- rtl/afs_back.sv -----
`timescale 1ns / 1ps

module afs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  afs_pkg::entry_t                    head,
  input  afs_pkg::qstat_t                    stat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [afs_pkg::TDATA_BITS-1:0]     out_data,
  output logic [1:0]                         out_user,
  output logic                               out_last
);

  afs_pkg::entry_t pend;
  logic            pend_valid;
  logic            load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_valid && !stat.empty;

  function automatic logic [afs_pkg::TDATA_BITS-1:0] pack(afs_pkg::entry_t e, logic [7:0] b);
    pack = {5'd0, e.frame_number, e.frame_length, e.rate_index, e.profile, b};
  endfunction

  always_ff @(posedge clk) begin
    if (pop) pend <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      out_data   <= '0;
      out_user   <= afs_pkg::ST_INSIDE;
      out_last   <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        // second half of a sync pair
        out_valid  <= 1'b1;
        out_data   <= pack(pend, pend.byte1);
        out_user   <= pend.status;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!stat.empty) begin
        out_valid  <= 1'b1;
        out_data   <= pack(head, head.byte0);
        out_user   <= head.two ? afs_pkg::ST_INSIDE : head.status;
        out_last   <= !head.two;
        pend_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/adts_frame_splitter_core.sv -----
`timescale 1ns / 1ps

// channel  | dir | tdata (low bit up)                                    | tuser        | tlast
// s_axis   | in  | data_byte[7:0]                                        | -            | stream_end
// m_axis   | out | frame_byte, profile, rate_index, frame_length,        | frame_status | run_last
//          |     | frame_number, zero pad to 48                          |              |
//
// One byte accepted per cycle while s_axis_tready is high; results leave one per cycle while
// m_axis_tready is high, so a sync pair leaves as two results. An input request reaches the first
// output through the front register, the queue write and the output register.
// A four-entry queue between classifier and output stage absorbs the extra sync result;
// s_axis_tready drops when the queue is nearly full, m_axis stalls back up into it.
// Synchronous active-high reset returns the parser to sync search with counters at zero.

module adts_frame_splitter_core #(
  parameter int FRAME_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // frame_byte, profile, rate_index, frame_length, frame_number
  output logic [1:0]  m_axis_tuser,   // frame_status
  output logic        m_axis_tlast    // run_last
);

  afs_pkg::push_t  push;
  afs_pkg::entry_t head;
  afs_pkg::qstat_t stat;
  logic            pop;
  logic            in_accept;

  assign s_axis_tready = !stat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  afs_front #(
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (s_axis_tdata),
    .stream_end (s_axis_tlast),
    .push       (push)
  );

  afs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  afs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // any non-inside status ends the run for its byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != afs_pkg::ST_INSIDE |-> m_axis_tlast)
    else $error("terminal status without tlast");

  // only the sync byte of a pair is a non-last result
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[7:0] == afs_pkg::SYNC_BYTE && m_axis_tuser == afs_pkg::ST_INSIDE)
    else $error("non-last result is not a sync byte");

  // the front pushes only for a byte accepted while the queue was not full
  assert property (@(posedge clk) disable iff (rst)
    $past(stat.full) && stat.full && !$past(pop) |-> !push.valid || !$past(in_accept))
    else $error("queue overrun");

endmodule

// ----- verif/adts_frame_splitter_core_tb.sv -----
`timescale 1ns / 1ps

module adts_frame_splitter_core_tb;

  localparam int unsigned BYTE_TARGET = 1720;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum bit [1:0] {HUNT, GOT_SYNC, IN_FRAME} parse_phase_t;

  typedef struct {
    bit [7:0]  fbyte;
    bit [1:0]  status;
    bit        run_last;
    bit [1:0]  profile;
    bit [3:0]  rate_index;
    bit [12:0] frame_length;
    bit [15:0] frame_number;
  } frame_result_t;

  class frame_scoreboard;
    parse_phase_t  phase;
    bit [12:0]     pos;
    bit [1:0]      profile;
    bit [3:0]      rate_index;
    bit [12:0]     frame_length;
    bit [15:0]     frames_completed;
    frame_result_t expected_q[$];
    int unsigned   errors;
    int unsigned   results_checked;
    int unsigned   status_seen[4];

    function new();
      phase = HUNT;
      pos = '0;
      profile = '0;
      rate_index = '0;
      frame_length = '0;
      frames_completed = '0;
      errors = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void queue_result(bit [7:0] b, bit [1:0] st, bit lst);
      frame_result_t r;
      r.fbyte = b;
      r.status = st;
      r.run_last = lst;
      r.profile = profile;
      r.rate_index = rate_index;
      r.frame_length = frame_length;
      r.frame_number = frames_completed;
      expected_q.push_back(r);
    endfunction

    // advance the parser by one accepted byte and queue what it produces
    function void note_byte(bit [7:0] b, bit last);
      bit [1:0] st;
      bit       done;
      case (phase)
        HUNT: begin
          if (b == afs_pkg::SYNC_BYTE && !last) phase = GOT_SYNC;
        end
        GOT_SYNC: begin
          if (b[7:4] != afs_pkg::SYNC_NIB) begin
            phase = HUNT;
          end else begin
            profile = '0;
            rate_index = '0;
            frame_length = '0;
            queue_result(afs_pkg::SYNC_BYTE, afs_pkg::ST_INSIDE, 1'b0);
            queue_result(b, last ? afs_pkg::ST_TRUNC : afs_pkg::ST_INSIDE, 1'b1);
            pos = 13'd2;
            phase = last ? HUNT : IN_FRAME;
          end
        end
        default: begin
          st = afs_pkg::ST_INSIDE;
          done = 1'b0;
          case (pos)
            13'd2: begin
              profile = b[7:6];
              rate_index = b[5:2];
            end
            13'd3: frame_length = {b[1:0], 11'd0};
            13'd4: frame_length = frame_length | {2'd0, b, 3'd0};
            13'd5: begin
              frame_length = frame_length | {10'd0, b[7:5]};
              if (frame_length < afs_pkg::MIN_LENGTH) begin
                st = afs_pkg::ST_BADLEN;
                done = 1'b1;
              end
            end
            default: begin
              if (pos >= 13'd6 && ({1'b0, pos} + 14'd1) >= {1'b0, frame_length}) begin
                st = afs_pkg::ST_DONE;
                done = 1'b1;
              end
            end
          endcase
          // a frame end wins over stream end on the same byte
          if (!done && last) st = afs_pkg::ST_TRUNC;
          queue_result(b, st, 1'b1);
          if (st == afs_pkg::ST_DONE) frames_completed = frames_completed + 16'd1;
          if (done || last) begin
            phase = HUNT;
            pos = '0;
          end else begin
            pos = pos + 13'd1;
          end
        end
      endcase
    endfunction

    function void report(string what, frame_result_t e, logic [47:0] td, logic [1:0] tu,
                         logic tl);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] %s", $realtime, what);
        $display("  exp: byte %02h st %0d last %0d prof %0d rate %0d len %0d num %0d",
                 e.fbyte, e.status, e.run_last, e.profile, e.rate_index, e.frame_length,
                 e.frame_number);
        $display("  got: byte %02h st %0d last %0d prof %0d rate %0d len %0d num %0d pad %h",
                 td[7:0], tu, tl, td[9:8], td[13:10], td[26:14], td[42:27], td[47:43]);
      end
    endfunction

    function void check_result(logic [47:0] td, logic [1:0] tu, logic tl);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        e = '{default: '0};
        report("result with nothing expected", e, td, tu, tl);
      end else begin
        e = expected_q.pop_front();
        results_checked++;
        status_seen[e.status]++;
        if (td[7:0] !== e.fbyte || tu !== e.status || tl !== e.run_last ||
            td[9:8] !== e.profile || td[13:10] !== e.rate_index ||
            td[26:14] !== e.frame_length || td[42:27] !== e.frame_number ||
            td[47:43] !== 5'd0)
          report("result mismatch", e, td, tu, tl);
      end
    endfunction

    function void flush_leftovers();
      if (expected_q.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  frame_scoreboard sb = new();
  bit              idle_on = 1'b1;
  int unsigned     bytes_sent = 0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;

  adts_frame_splitter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.expected_q.size());
      $display("adts_frame_splitter_core regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      if (stall_left != 0) stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic send_byte(input bit [7:0] b, input bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // header byte 2 carries profile and rate index; nsend may cut the frame short
  task automatic send_frame(input int unsigned flen, input int unsigned nsend,
                            input bit end_flag, input bit double_ff, input bit [7:0] b2);
    bit [12:0]   fl;
    bit [7:0]    hdr[7];
    bit [7:0]    b;
    int unsigned i;
    fl = flen[12:0];
    hdr[0] = afs_pkg::SYNC_BYTE;
    hdr[1] = double_ff ? afs_pkg::SYNC_BYTE : {afs_pkg::SYNC_NIB, 4'($urandom)};
    hdr[2] = b2;
    hdr[3] = {6'($urandom), fl[12:11]};
    hdr[4] = fl[10:3];
    hdr[5] = {fl[2:0], 5'($urandom)};
    hdr[6] = 8'($urandom);
    for (i = 0; i < nsend; i++) begin
      b = (i < 7) ? hdr[i] : 8'($urandom);
      send_byte(b, end_flag && i == nsend - 1);
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned i;
    bit [7:0]    b;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       b = afs_pkg::SYNC_BYTE;
        1:       b = {afs_pkg::SYNC_NIB, 4'($urandom)};
        default: b = 8'($urandom);
      endcase
      send_byte(b, (i == n - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int unsigned flen;
    int unsigned nsend;
    int unsigned kind;
    bit          cut;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sync byte marked last while hunting
    send_byte(afs_pkg::SYNC_BYTE, 1'b1);
    // sync byte followed by a byte without the high nibble
    send_byte(afs_pkg::SYNC_BYTE, 1'b0);
    send_byte(8'h0F, 1'b0);
    // stream ends on the second sync byte
    send_byte(afs_pkg::SYNC_BYTE, 1'b0);
    send_byte(8'hF1, 1'b1);
    // shortest legal frame, two 0xFF to start, top profile and rate, ends with stream
    send_frame(7, 7, 1'b1, 1'b1, 8'hFF);
    // length just under the minimum, stream end on the same byte
    send_frame(6, 6, 1'b1, 1'b0, 8'h00);
    // cut inside the header
    send_frame(300, 3, 1'b1, 1'b0, 8'h5A);

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 19) == 0) idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 400) : $urandom_range(7, 40);
        cut = ($urandom_range(0, 9) == 0);
        nsend = cut ? $urandom_range(2, flen - 1) : flen;
        send_frame(flen, nsend, cut || ($urandom_range(0, 7) == 0),
                   $urandom_range(0, 7) == 0, 8'($urandom));
      end else if (kind < 78) begin
        flen = $urandom_range(0, 6);
        nsend = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 6;
        send_frame(flen, nsend, $urandom_range(0, 2) == 0, 1'b0, 8'($urandom));
      end else begin
        send_noise();
      end
    end

    // largest length in the header, sent back to back and cut short by stream end
    idle_on = 1'b0;
    send_frame(8191, 200, 1'b1, 1'b0, 8'($urandom));
    idle_on = 1'b1;
    send_frame(7, 7, 1'b0, 1'b0, 8'($urandom));

    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    sb.flush_leftovers();

    $display("%0d bytes in, %0d results checked", bytes_sent, sb.results_checked);
    $display("frames complete %0d, bad length %0d, truncated %0d, mismatches %0d",
             sb.status_seen[afs_pkg::ST_DONE], sb.status_seen[afs_pkg::ST_BADLEN],
             sb.status_seen[afs_pkg::ST_TRUNC], sb.errors);
    if (sb.errors == 0) begin
      $display("adts_frame_splitter_core regression: pass");
    end else begin
      $display("adts_frame_splitter_core regression: fail");
    end
    $finish;
  end

endmodule
